@@ src/occq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occq_pkg
// Shared codes, field widths and controller/datapath link types for the
// obstacle collision query block.
// ----------------------------------------------------------------------------
package occq_pkg;

  localparam int CMD_W   = 2;
  localparam int SLOT_W  = 4;
  localparam int POS_W   = 13;
  localparam int SIZE_W  = 11;
  localparam int COLOR_W = 2;
  localparam int HIT_W   = 4;
  localparam int STAT_W  = 2;

  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_MOVE   = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_UNUSED = 2'd2;

  typedef struct packed {
    logic load;
    logic exec;
    logic scan_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_query;
    logic is_empty;
    logic scan_last;
    logic pipe_busy;
  } dp_stat_t;

endpackage

@@ src/occq_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occq_if
// Command and result channels of the obstacle collision query block.
// ----------------------------------------------------------------------------
interface occq_in_if;
  logic                                valid;
  logic                                ready;
  logic        [occq_pkg::CMD_W-1:0]   cmd;
  logic        [occq_pkg::SLOT_W-1:0]  slot;
  logic                                kind;
  logic signed [occq_pkg::POS_W-1:0]   pos_x;
  logic signed [occq_pkg::POS_W-1:0]   pos_y;
  logic        [occq_pkg::SIZE_W-1:0]  size_a;
  logic        [occq_pkg::SIZE_W-1:0]  size_b;
  logic        [occq_pkg::COLOR_W-1:0] color;

  modport source (output valid, cmd, slot, kind, pos_x, pos_y, size_a, size_b, color,
                  input ready);
  modport sink (input valid, cmd, slot, kind, pos_x, pos_y, size_a, size_b, color,
                output ready);
endinterface

interface occq_out_if;
  logic                               valid;
  logic                               ready;
  logic                               found;
  logic [occq_pkg::HIT_W-1:0]         hit_index;
  logic [occq_pkg::STAT_W-1:0]        status;

  modport source (output valid, found, hit_index, status, input ready);
  modport sink (input valid, found, hit_index, status, output ready);
endinterface

@@ src/occq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occq_ctrl
// Sequencer: accepts one item, runs its command on the datapath, scans the
// table for queries and hands the result to the output register.
// ----------------------------------------------------------------------------
module occq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output occq_pkg::dp_cmd_t  cmd,
  input  occq_pkg::dp_stat_t stat
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state, state_next;
  logic       out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd.load      = in_valid && in_ready;
    cmd.exec      = (state == ST_EXEC);
    cmd.scan_step = (state == ST_SCAN);
    cmd.out_load  = (state == ST_DONE) && out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (stat.is_query && !stat.is_empty) state_next = ST_SCAN;
        else state_next = ST_DONE;
      end
      ST_SCAN: begin
        if (stat.scan_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_pipe_idle : assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE || state == ST_DONE) |-> !stat.pipe_busy)
    else $error("scan pipeline active outside a query");

  a_out_from_done : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result presented without a finished item");

  a_out_hold : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while held off");

endmodule

@@ src/occq_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occq_dp
// Datapath: obstacle table memories, entry count, scan pipeline
// with overlap tests and nearest-hit tracking, and the output register.
// ----------------------------------------------------------------------------
module occq_dp #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  occq_pkg::dp_cmd_t                   cmd,
  output occq_pkg::dp_stat_t                  stat,
  input  logic        [occq_pkg::CMD_W-1:0]   in_cmd,
  input  logic        [occq_pkg::SLOT_W-1:0]  in_slot,
  input  logic                                in_kind,
  input  logic signed [occq_pkg::POS_W-1:0]   in_pos_x,
  input  logic signed [occq_pkg::POS_W-1:0]   in_pos_y,
  input  logic        [occq_pkg::SIZE_W-1:0]  in_size_a,
  input  logic        [occq_pkg::SIZE_W-1:0]  in_size_b,
  input  logic        [occq_pkg::COLOR_W-1:0] in_color,
  output logic                                out_found,
  output logic        [occq_pkg::HIT_W-1:0]   out_hit_index,
  output logic        [occq_pkg::STAT_W-1:0]  out_status
);

  localparam int POS_W  = occq_pkg::POS_W;
  localparam int SIZE_W = occq_pkg::SIZE_W;
  localparam int COL_W  = occq_pkg::COLOR_W;
  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W  = (CNT_W > occq_pkg::SLOT_W) ? CNT_W : occq_pkg::SLOT_W;
  localparam int D_W    = POS_W + 1;
  localparam int S_W    = SIZE_W + 1;
  localparam int SQ_W   = 2 * POS_W + 1;
  localparam int DIST_W = 2 * POS_W + 2;
  localparam int SS_W   = 2 * S_W;
  localparam int ATTR_W = 1 + 2 * SIZE_W + COL_W;

  // captured item
  logic        [occq_pkg::CMD_W-1:0]  q_cmd;
  logic        [occq_pkg::SLOT_W-1:0] q_slot;
  logic                               q_kind;
  logic signed [POS_W-1:0]            q_x, q_y;
  logic        [SIZE_W-1:0]           q_a, q_b;
  logic        [COL_W-1:0]            q_color;

  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] ptr;
  logic             full, slot_bad;
  logic             wr_attr, wr_pos;
  logic [IDX_W-1:0] wr_idx;

  logic [2*POS_W-1:0]  pos_mem  [TABLE_DEPTH];
  logic [ATTR_W-1:0]   attr_mem [TABLE_DEPTH];

  // stage 1: table read
  logic                v1;
  logic [IDX_W-1:0]    i1;
  logic [2*POS_W-1:0]  rd_pos;
  logic [ATTR_W-1:0]   rd_attr;
  // stage 2: differences and grown extents
  logic                v2, k2, m2;
  logic [IDX_W-1:0]    i2;
  logic signed [D_W-1:0] dx2, dy2;
  logic [S_W-1:0]      sa2, sb2;
  // stage 3: squares and rectangle test
  logic                v3, k3, m3, rect3;
  logic [IDX_W-1:0]    i3;
  logic [SQ_W-1:0]     sqx3, sqy3;
  logic [SS_W-1:0]     sqs3;
  // stage 4: distance and hit
  logic                v4, h4;
  logic [IDX_W-1:0]    i4;
  logic [DIST_W-1:0]   d4;
  // running best
  logic                r_found;
  logic [IDX_W-1:0]    r_hit;
  logic [occq_pkg::STAT_W-1:0] r_status;
  logic [DIST_W-1:0]   best_d;

  // combinational temporaries
  logic signed [POS_W-1:0]  e_x, e_y;
  logic                     e_kind;
  logic [SIZE_W-1:0]        e_a, e_b;
  logic [COL_W-1:0]         e_color;
  logic signed [2*D_W-1:0]  px, py;
  logic [D_W-1:0]           ax, ay;
  logic [DIST_W-1:0]        sum_sq;

  assign full     = (count == CNT_W'(TABLE_DEPTH));
  assign slot_bad = (CMP_W'(q_slot) >= CMP_W'(count));
  assign wr_attr  = cmd.exec && (q_cmd == occq_pkg::CMD_APPEND) && !full;
  assign wr_pos   = wr_attr || (cmd.exec && (q_cmd == occq_pkg::CMD_MOVE) && !slot_bad);
  assign wr_idx   = (q_cmd == occq_pkg::CMD_MOVE) ? IDX_W'(q_slot) : count[IDX_W-1:0];

  always_comb begin
    stat.is_query  = (q_cmd == occq_pkg::CMD_QUERY);
    stat.is_empty  = (count == '0);
    stat.scan_last = (CNT_W'(ptr) == count - CNT_W'(1));
    stat.pipe_busy = v1 || v2 || v3 || v4;
  end

  always_comb begin
    {e_x, e_y}                  = rd_pos;
    {e_kind, e_a, e_b, e_color} = rd_attr;
    px     = dx2 * dx2;
    py     = dy2 * dy2;
    ax     = dx2[D_W-1] ? D_W'(-dx2) : D_W'(dx2);
    ay     = dy2[D_W-1] ? D_W'(-dy2) : D_W'(dy2);
    sum_sq = DIST_W'(sqx3) + DIST_W'(sqy3);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_cmd   <= in_cmd;
      q_slot  <= in_slot;
      q_kind  <= in_kind;
      q_x     <= in_pos_x;
      q_y     <= in_pos_y;
      q_a     <= in_size_a;
      q_b     <= in_size_b;
      q_color <= in_color;
    end
    if (wr_pos) pos_mem[wr_idx] <= {q_x, q_y};
    if (wr_attr) attr_mem[wr_idx] <= {q_kind, q_a, q_b, q_color};
    rd_pos  <= pos_mem[ptr];
    rd_attr <= attr_mem[ptr];
    i1      <= ptr;
    // stage 2
    dx2 <= D_W'(q_x) - D_W'(e_x);
    dy2 <= D_W'(q_y) - D_W'(e_y);
    sa2 <= S_W'(e_a) + S_W'(q_a);
    sb2 <= S_W'(e_b) + S_W'(q_a);
    k2  <= e_kind;
    m2  <= (e_color == q_color);
    i2  <= i1;
    // stage 3
    sqx3  <= px[SQ_W-1:0];
    sqy3  <= py[SQ_W-1:0];
    sqs3  <= sa2 * sa2;
    rect3 <= (ax < D_W'(sa2)) && (ay < D_W'(sb2));
    k3    <= k2;
    m3    <= m2;
    i3    <= i2;
    // stage 4
    d4 <= sum_sq;
    h4 <= m3 && (k3 ? rect3 : (sum_sq < DIST_W'(sqs3)));
    i4 <= i3;
    if (cmd.out_load) begin
      out_found     <= r_found;
      out_hit_index <= occq_pkg::HIT_W'(r_hit);
      out_status    <= r_status;
    end
    if (v4 && h4 && (!r_found || d4 < best_d)) best_d <= d4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      ptr      <= '0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      v4       <= 1'b0;
      r_found  <= 1'b0;
      r_hit    <= '0;
      r_status <= occq_pkg::STAT_OK;
    end else begin
      v1 <= cmd.scan_step;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      if (cmd.scan_step) ptr <= ptr + IDX_W'(1);
      if (cmd.exec) begin
        ptr      <= '0;
        r_found  <= 1'b0;
        r_hit    <= '0;
        r_status <= occq_pkg::STAT_OK;
        unique case (q_cmd)
          occq_pkg::CMD_APPEND: begin
            if (full) r_status <= occq_pkg::STAT_FULL;
            else count <= count + CNT_W'(1);
          end
          occq_pkg::CMD_MOVE: begin
            if (slot_bad) r_status <= occq_pkg::STAT_UNUSED;
          end
          occq_pkg::CMD_CLEAR: count <= '0;
          occq_pkg::CMD_QUERY: ;
          default: ;
        endcase
      end else if (v4 && h4 && (!r_found || d4 < best_d)) begin
        r_found <= 1'b1;
        r_hit   <= i4;
      end
    end
  end

  a_count_range : assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_no_write_in_scan : assert property (@(posedge clk) disable iff (rst)
    stat.pipe_busy |-> !wr_pos && !wr_attr)
    else $error("table written during a scan");

  a_error_no_hit : assert property (@(posedge clk) disable iff (rst)
    (r_status != occq_pkg::STAT_OK) |-> !r_found)
    else $error("hit reported with an error status");

endmodule

@@ src/obstacle_circle_collision_query.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obstacle_circle_collision_query
// Obstacle table of circles and rectangles with nearest-hit disc query.
// ----------------------------------------------------------------------------
// One item is handled at a time. Append, move and clear run in an execute
// state and then hand their result to the output register. A query reads the
// table through a single memory read port, one entry per cycle, into a
// four-stage test pipeline and waits for it to drain before its result goes
// out; a query on an empty table skips the scan. The next item is accepted
// while a finished result waits in the output register. A query reports the
// overlapping entry of the requested color with the smallest squared center
// distance, the lowest index on ties; hit_index carries the low four bits of
// the entry index.
module obstacle_circle_collision_query #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  occq_in_if.sink           item_in,
  occq_out_if.source        item_out
);

  occq_pkg::dp_cmd_t  cmd;
  occq_pkg::dp_stat_t stat;

  occq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item_in.valid),
    .in_ready  (item_in.ready),
    .out_valid (item_out.valid),
    .out_ready (item_out.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  occq_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .in_cmd        (item_in.cmd),
    .in_slot       (item_in.slot),
    .in_kind       (item_in.kind),
    .in_pos_x      (item_in.pos_x),
    .in_pos_y      (item_in.pos_y),
    .in_size_a     (item_in.size_a),
    .in_size_b     (item_in.size_b),
    .in_color      (item_in.color),
    .out_found     (item_out.found),
    .out_hit_index (item_out.hit_index),
    .out_status    (item_out.status)
  );

endmodule

@@ sim/obstacle_query_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obstacle_query_checker
// Watches the command and result channels of the obstacle collision query
// block. Keeps its own obstacle table, works out the result of every accepted
// command item and compares each accepted result item field by field with the
// oldest outstanding one.
// ----------------------------------------------------------------------------
module obstacle_query_checker #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  occq_in_if   item_in,
  occq_out_if  item_out,
  output int   mismatches,
  output int   outstanding
);

  localparam int CMD_W   = occq_pkg::CMD_W;
  localparam int SLOT_W  = occq_pkg::SLOT_W;
  localparam int POS_W   = occq_pkg::POS_W;
  localparam int SIZE_W  = occq_pkg::SIZE_W;
  localparam int COLOR_W = occq_pkg::COLOR_W;
  localparam int HIT_W   = occq_pkg::HIT_W;
  localparam int STAT_W  = occq_pkg::STAT_W;

  localparam logic [CMD_W-1:0] CMD_APPEND = occq_pkg::CMD_APPEND;
  localparam logic [CMD_W-1:0] CMD_QUERY  = occq_pkg::CMD_QUERY;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = occq_pkg::CMD_CLEAR;
  localparam logic [CMD_W-1:0] CMD_MOVE   = occq_pkg::CMD_MOVE;

  localparam logic [STAT_W-1:0] STAT_FULL   = occq_pkg::STAT_FULL;
  localparam logic [STAT_W-1:0] STAT_UNUSED = occq_pkg::STAT_UNUSED;

  typedef struct packed {
    logic              found;
    logic [HIT_W-1:0]  hit_index;
    logic [STAT_W-1:0] status;
  } query_result_t;

  query_result_t             pending_results[$];
  int                        stored;
  logic                      ob_rect  [TABLE_DEPTH];
  logic signed [POS_W-1:0]   ob_x     [TABLE_DEPTH];
  logic signed [POS_W-1:0]   ob_y     [TABLE_DEPTH];
  logic        [SIZE_W-1:0]  ob_a     [TABLE_DEPTH];
  logic        [SIZE_W-1:0]  ob_b     [TABLE_DEPTH];
  logic        [COLOR_W-1:0] ob_color [TABLE_DEPTH];

  initial begin
    mismatches  = 0;
    outstanding = 0;
    stored      = 0;
  end

  function automatic logic disc_overlaps(int i, longint qx, longint qy, longint r);
    longint ex, ey, a, b, dx, dy;
    ex = ob_x[i];
    ey = ob_y[i];
    a  = ob_a[i];
    b  = ob_b[i];
    if (!ob_rect[i]) begin
      dx = qx - ex;
      dy = qy - ey;
      return dx * dx + dy * dy < (a + r) * (a + r);
    end
    return (ex - a - r) < qx && qx < (ex + a + r) &&
           (ey - b - r) < qy && qy < (ey + b + r);
  endfunction

  function automatic query_result_t apply_command(
    logic        [CMD_W-1:0]   cmd,
    logic        [SLOT_W-1:0]  slot,
    logic                      kind,
    logic signed [POS_W-1:0]   px,
    logic signed [POS_W-1:0]   py,
    logic        [SIZE_W-1:0]  sa,
    logic        [SIZE_W-1:0]  sb,
    logic        [COLOR_W-1:0] color
  );
    query_result_t res;
    longint        qx, qy, dx, dy, d_sq, best;
    res  = '0;
    qx   = px;
    qy   = py;
    best = 0;
    case (cmd)
      CMD_APPEND: begin
        if (stored >= TABLE_DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          ob_rect[stored]  = kind;
          ob_x[stored]     = px;
          ob_y[stored]     = py;
          ob_a[stored]     = sa;
          ob_b[stored]     = sb;
          ob_color[stored] = color;
          stored++;
        end
      end
      CMD_QUERY: begin
        for (int i = 0; i < stored; i++) begin
          if (ob_color[i] == color && disc_overlaps(i, qx, qy, longint'(sa))) begin
            dx   = qx - ob_x[i];
            dy   = qy - ob_y[i];
            d_sq = dx * dx + dy * dy;
            if (!res.found || d_sq < best) begin
              res.found     = 1'b1;
              res.hit_index = HIT_W'(i);
              best          = d_sq;
            end
          end
        end
      end
      CMD_CLEAR: begin
        stored = 0;
      end
      CMD_MOVE: begin
        if (int'(slot) >= stored) begin
          res.status = STAT_UNUSED;
        end else begin
          ob_x[slot] = px;
          ob_y[slot] = py;
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic report(string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    query_result_t exp_r;
    if (rst) begin
      pending_results.delete();
      stored = 0;
    end else begin
      if (item_out.valid === 1'b1 && item_out.ready === 1'b1) begin
        if (pending_results.size() == 0) begin
          report("result item with no command outstanding");
        end else begin
          exp_r = pending_results.pop_front();
          if (item_out.found !== exp_r.found)
            report($sformatf("found: expected %0d, got %0d", exp_r.found, item_out.found));
          if (item_out.hit_index !== exp_r.hit_index)
            report($sformatf("hit_index: expected %0d, got %0d",
                             exp_r.hit_index, item_out.hit_index));
          if (item_out.status !== exp_r.status)
            report($sformatf("status: expected %0d, got %0d", exp_r.status, item_out.status));
        end
      end
      if (item_in.valid === 1'b1 && item_in.ready === 1'b1) begin
        pending_results.insert(pending_results.size(),
                               apply_command(item_in.cmd, item_in.slot, item_in.kind,
                                             item_in.pos_x, item_in.pos_y,
                                             item_in.size_a, item_in.size_b,
                                             item_in.color));
      end
    end
    outstanding = pending_results.size();
  end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives command items into the obstacle collision query block: a directed
// pass over boundaries, ties, a full table and unused slots, then random
// episodes that build a small table and query around its entries. Both
// channels idle in short random bursts, and once the result side holds off
// long enough to back the block up. The checker beside the block counts
// mismatches; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CMD_W   = occq_pkg::CMD_W;
  localparam int SLOT_W  = occq_pkg::SLOT_W;
  localparam int POS_W   = occq_pkg::POS_W;
  localparam int SIZE_W  = occq_pkg::SIZE_W;
  localparam int COLOR_W = occq_pkg::COLOR_W;

  localparam logic [CMD_W-1:0] CMD_APPEND = occq_pkg::CMD_APPEND;
  localparam logic [CMD_W-1:0] CMD_QUERY  = occq_pkg::CMD_QUERY;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = occq_pkg::CMD_CLEAR;
  localparam logic [CMD_W-1:0] CMD_MOVE   = occq_pkg::CMD_MOVE;

  localparam int TABLE_DEPTH  = 16;
  localparam int RANDOM_ITEMS = 500;
  localparam int CALM_ITEMS   = 80;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 250;
  localparam int TAIL_CYCLES  = 60;
  localparam int POS_MIN      = -4096;
  localparam int POS_MAX      = 4095;
  localparam int SIZE_MAX     = 2047;

  localparam logic KIND_CIRCLE = 1'b0;
  localparam logic KIND_RECT   = 1'b1;

  localparam logic [COLOR_W-1:0] COLOR_NEUTRAL = 2'd0;
  localparam logic [COLOR_W-1:0] COLOR_BLACK   = 2'd1;
  localparam logic [COLOR_W-1:0] COLOR_RED     = 2'd2;
  localparam logic [COLOR_W-1:0] COLOR_BLUE    = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #6 clk = ~clk;

  occq_in_if  cmd_ch ();
  occq_out_if res_ch ();

  int mismatches;
  int outstanding;

  obstacle_circle_collision_query #(.TABLE_DEPTH(TABLE_DEPTH)) DUT (
    .clk      (clk),
    .rst      (rst),
    .item_in  (cmd_ch),
    .item_out (res_ch)
  );

  obstacle_query_checker #(.TABLE_DEPTH(TABLE_DEPTH)) checker_i (
    .clk         (clk),
    .rst         (rst),
    .item_in     (cmd_ch),
    .item_out    (res_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  bit tx_idle  = 1'b1;
  bit rx_idle  = 1'b1;
  bit hold_req = 1'b0;
  int sent     = 0;

  // rough copy of the table, used only to aim queries and moves
  int   sh_n = 0;
  int   sh_x [TABLE_DEPTH];
  int   sh_y [TABLE_DEPTH];
  int   sh_a [TABLE_DEPTH];
  int   sh_b [TABLE_DEPTH];
  logic [COLOR_W-1:0] sh_c [TABLE_DEPTH];

  function automatic int clamp_pos(int v);
    if (v < POS_MIN) return POS_MIN;
    if (v > POS_MAX) return POS_MAX;
    return v;
  endfunction

  function automatic int rand_pos();
    int v;
    v = $urandom_range(0, 8191);
    return v - 4096;
  endfunction

  function automatic int near_pos(int c, int spread);
    int off;
    off = $urandom_range(0, 2 * spread);
    return clamp_pos(c + off - spread);
  endfunction

  function automatic int rand_size();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(0, 300);
    if (pick < 92) return $urandom_range(0, SIZE_MAX);
    if (pick < 96) return 0;
    return SIZE_MAX;
  endfunction

  task automatic send(logic [CMD_W-1:0] cmd, int slot, logic kind,
                      int x, int y, int a, int b, logic [COLOR_W-1:0] color);
    if (tx_idle && $urandom_range(0, 4) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    cmd_ch.valid  <= 1'b1;
    cmd_ch.cmd    <= cmd;
    cmd_ch.slot   <= SLOT_W'(slot);
    cmd_ch.kind   <= kind;
    cmd_ch.pos_x  <= POS_W'(x);
    cmd_ch.pos_y  <= POS_W'(y);
    cmd_ch.size_a <= SIZE_W'(a);
    cmd_ch.size_b <= SIZE_W'(b);
    cmd_ch.color  <= color;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    sent++;
    case (cmd)
      CMD_APPEND: begin
        if (sh_n < TABLE_DEPTH) begin
          sh_x[sh_n] = x;
          sh_y[sh_n] = y;
          sh_a[sh_n] = a;
          sh_b[sh_n] = b;
          sh_c[sh_n] = color;
          sh_n++;
        end
      end
      CMD_CLEAR: sh_n = 0;
      CMD_MOVE: begin
        if (slot < sh_n) begin
          sh_x[slot] = x;
          sh_y[slot] = y;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic append_random();
    int x, y, i;
    x = rand_pos();
    y = rand_pos();
    if (sh_n > 0 && $urandom_range(0, 9) < 6) begin
      i = $urandom_range(0, sh_n - 1);
      // duplicate centers now and then to force distance ties
      if ($urandom_range(0, 5) == 0) begin
        x = sh_x[i];
        y = sh_y[i];
      end else begin
        x = near_pos(sh_x[i], 400);
        y = near_pos(sh_y[i], 400);
      end
    end
    send(CMD_APPEND, int'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), x, y,
         rand_size(), rand_size(), COLOR_W'($urandom_range(0, 3)));
  endtask

  // result side: short stalls, plus one long hold-off on request
  initial begin
    res_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (rx_idle && $urandom_range(0, 3) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        res_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("obstacle_circle_collision_query: mismatch");
    $finish;
  end

  initial begin : stimulus
    int n, ops, pick, i, r, spread;
    bit held;
    logic [COLOR_W-1:0] qc;
    held          = 1'b0;
    cmd_ch.valid  = 1'b0;
    cmd_ch.cmd    = CMD_CLEAR;
    cmd_ch.slot   = '0;
    cmd_ch.kind   = KIND_CIRCLE;
    cmd_ch.pos_x  = '0;
    cmd_ch.pos_y  = '0;
    cmd_ch.size_a = '0;
    cmd_ch.size_b = '0;
    cmd_ch.color  = COLOR_NEUTRAL;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // empty table, unused slot, ties, strict boundaries, extremes
    send(CMD_QUERY, 0, KIND_CIRCLE, POS_MIN, POS_MAX, SIZE_MAX, SIZE_MAX, COLOR_NEUTRAL);
    send(CMD_MOVE, 0, KIND_CIRCLE, 0, 0, 0, 0, COLOR_NEUTRAL);
    send(CMD_APPEND, 0, KIND_CIRCLE, 0, 0, 100, 0, COLOR_BLACK);
    send(CMD_APPEND, 0, KIND_CIRCLE, 0, 0, 50, 0, COLOR_BLACK);
    send(CMD_QUERY, 0, KIND_CIRCLE, 0, 0, 0, 0, COLOR_BLACK);
    send(CMD_QUERY, 0, KIND_CIRCLE, 150, 0, 50, 0, COLOR_BLACK);
    send(CMD_QUERY, 0, KIND_CIRCLE, 149, 0, 50, 0, COLOR_BLACK);
    send(CMD_APPEND, 0, KIND_RECT, POS_MAX, POS_MIN, SIZE_MAX, 0, COLOR_BLUE);
    send(CMD_QUERY, 0, KIND_CIRCLE, POS_MAX, POS_MIN, 0, 0, COLOR_BLUE);
    send(CMD_QUERY, 0, KIND_CIRCLE, POS_MAX, POS_MIN, 1, 0, COLOR_BLUE);
    send(CMD_APPEND, 0, KIND_CIRCLE, POS_MIN, POS_MAX, SIZE_MAX, SIZE_MAX, COLOR_RED);
    send(CMD_QUERY, 0, KIND_CIRCLE, POS_MAX, POS_MIN, SIZE_MAX, 0, COLOR_RED);
    send(CMD_MOVE, 3, KIND_RECT, POS_MAX, POS_MIN, SIZE_MAX, SIZE_MAX, COLOR_BLUE);
    send(CMD_QUERY, 0, KIND_CIRCLE, POS_MAX, POS_MIN, 0, 0, COLOR_RED);
    send(CMD_MOVE, 4, KIND_CIRCLE, 0, 0, 0, 0, COLOR_NEUTRAL);
    for (int k = 4; k < TABLE_DEPTH; k++)
      send(CMD_APPEND, k, 1'(k), k * 500 - 4096, 4095 - k * 500,
           k * 100, (k % 3 == 0) ? SIZE_MAX : k * 50, COLOR_W'(k));
    send(CMD_APPEND, 15, KIND_RECT, 0, 0, 10, 10, COLOR_NEUTRAL);
    send(CMD_QUERY, 0, KIND_CIRCLE, 0, 0, SIZE_MAX, 0, COLOR_NEUTRAL);
    send(CMD_CLEAR, 0, KIND_CIRCLE, 0, 0, 0, 0, COLOR_NEUTRAL);

    // random episodes: clear, build a table, then query and move around it
    n = sent;
    while (sent - n < RANDOM_ITEMS) begin
      send(CMD_CLEAR, int'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), rand_pos(),
           rand_pos(), rand_size(), rand_size(), COLOR_W'($urandom_range(0, 3)));
      pick = $urandom_range(0, 99);
      if (pick < 60) ops = $urandom_range(1, 6);
      else if (pick < 85) ops = $urandom_range(7, 16);
      else ops = $urandom_range(16, 18);
      repeat (ops) append_random();
      ops = $urandom_range(8, 25);
      repeat (ops) begin
        if (!held && sent - n >= HOLD_AT) begin
          held     = 1'b1;
          hold_req = 1'b1;
        end
        if (sent - n >= RANDOM_ITEMS - CALM_ITEMS) begin
          tx_idle = 1'b0;
          rx_idle = 1'b0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 55 && sh_n > 0) begin
          i      = $urandom_range(0, sh_n - 1);
          r      = ($urandom_range(0, 3) == 0) ? rand_size() : $urandom_range(0, 200);
          spread = ((sh_a[i] > sh_b[i]) ? sh_a[i] : sh_b[i]) + r + 16;
          qc     = ($urandom_range(0, 99) < 85) ? sh_c[i] : COLOR_W'($urandom_range(0, 3));
          send(CMD_QUERY, int'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
               near_pos(sh_x[i], spread), near_pos(sh_y[i], spread), r, rand_size(), qc);
        end else if (pick < 65) begin
          send(CMD_QUERY, int'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
               rand_pos(), rand_pos(), rand_size(), rand_size(), COLOR_W'($urandom_range(0, 3)));
        end else if (pick < 80) begin
          i = (sh_n > 0 && $urandom_range(0, 9) < 7) ? $urandom_range(0, sh_n - 1)
                                                      : $urandom_range(0, 15);
          send(CMD_MOVE, i, 1'($urandom_range(0, 1)),
               (sh_n > 0) ? near_pos(sh_x[$urandom_range(0, sh_n - 1)], 300) : rand_pos(),
               (sh_n > 0) ? near_pos(sh_y[$urandom_range(0, sh_n - 1)], 300) : rand_pos(),
               rand_size(), rand_size(), COLOR_W'($urandom_range(0, 3)));
        end else if (pick < 92) begin
          append_random();
        end else begin
          send(CMD_W'($urandom_range(0, 3)), int'($urandom_range(0, 15)),
               1'($urandom_range(0, 1)), rand_pos(), rand_pos(), rand_size(), rand_size(),
               COLOR_W'($urandom_range(0, 3)));
        end
      end
    end
    cmd_ch.valid <= 1'b0;

    @(posedge clk);
    wait (outstanding == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("obstacle_circle_collision_query: match");
    end else begin
      $display("obstacle_circle_collision_query: mismatch");
    end
    $finish;
  end

endmodule
